// File: design/pip_pkg.sv
// Shared constants, command codes and controller/datapath types for the point-in-polygon test.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_W      = 32;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int VERT_W       = 2 * COORD_W;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_TEST   = 2'd1,
        CMD_CLEAR  = 2'd2
    } pip_opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } pip_state_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic              rd_first;
        logic              start;
        logic              load_res;
        logic [ADDR_W-1:0] addr;
    } pip_cmd_t;

    typedef struct packed {
        logic busy;
    } pip_stat_t;

endpackage

`default_nettype wire

// File: design/pip_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/pip_dpath.sv
// Datapath: vertex store, edge difference, cross-multiply and parity pipeline.
`timescale 1ns / 1ps
`default_nettype none

module pip_dpath
    import pip_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pip_cmd_t                  cmd,
    input  wire logic signed [COORD_W-1:0] x_coord,
    input  wire logic signed [COORD_W-1:0] y_coord,
    output pip_stat_t                      stat,
    output logic                           inside_res
);

    logic [VERT_W-1:0] rdata;

    pip_ram #(
        .WIDTH(VERT_W),
        .DEPTH(MAX_VERTICES)
    ) u_store (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(cmd.addr),
        .wdata({x_coord, y_coord}),
        .re   (cmd.rd_en),
        .raddr(cmd.addr),
        .rdata(rdata)
    );

    logic signed [COORD_W-1:0] tx_reg, ty_reg;
    logic signed [COORD_W-1:0] xj_reg, yj_reg;
    logic                      rd_valid_reg, rd_first_reg;
    logic                      s1_valid_reg, s1_strad_reg, s1_dneg_reg;
    logic signed [DIFF_W-1:0]  s1_dtx_reg, s1_dy_reg, s1_ex_reg, s1_ey_reg;
    logic                      s2_valid_reg, s2_strad_reg, s2_dneg_reg;
    logic signed [PROD_W-1:0]  s2_lhs_reg, s2_rhs_reg;
    logic                      parity_reg, parity_next;
    logic                      inside_reg;

    logic signed [COORD_W-1:0] xi, yi;
    logic signed [DIFF_W-1:0]  dtx, dy, ex, ey;
    logic                      strad, left;

    assign xi = rdata[VERT_W-1:COORD_W];
    assign yi = rdata[COORD_W-1:0];

    always_comb
    begin
        dtx   = {tx_reg[COORD_W-1], tx_reg} - {xi[COORD_W-1], xi};
        dy    = {yj_reg[COORD_W-1], yj_reg} - {yi[COORD_W-1], yi};
        ex    = {xj_reg[COORD_W-1], xj_reg} - {xi[COORD_W-1], xi};
        ey    = {ty_reg[COORD_W-1], ty_reg} - {yi[COORD_W-1], yi};
        strad = (yi > ty_reg) != (yj_reg > ty_reg);
        // flip the comparison sense when the edge runs downward
        left  = s2_dneg_reg ? (s2_lhs_reg > s2_rhs_reg) : (s2_lhs_reg < s2_rhs_reg);
        parity_next = parity_reg;
        if (cmd.start)
        begin
            parity_next = 1'b0;
        end
        else if (s2_valid_reg && s2_strad_reg && left)
        begin
            parity_next = ~parity_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en && !cmd.rd_first;
            rd_first_reg <= cmd.rd_en && cmd.rd_first;
            s1_valid_reg <= rd_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            parity_reg   <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            tx_reg <= x_coord;
            ty_reg <= y_coord;
        end
        // the vertex just read becomes the trailing end of the next edge
        if (rd_first_reg || rd_valid_reg)
        begin
            xj_reg <= xi;
            yj_reg <= yi;
        end
        s1_strad_reg <= strad;
        s1_dneg_reg  <= dy[DIFF_W-1];
        s1_dtx_reg   <= dtx;
        s1_dy_reg    <= dy;
        s1_ex_reg    <= ex;
        s1_ey_reg    <= ey;
        s2_strad_reg <= s1_strad_reg;
        s2_dneg_reg  <= s1_dneg_reg;
        s2_lhs_reg   <= PROD_W'(s1_dtx_reg * s1_dy_reg);
        s2_rhs_reg   <= PROD_W'(s1_ex_reg * s1_ey_reg);
        if (cmd.load_res)
        begin
            inside_reg <= parity_reg;
        end
    end

    assign stat.busy  = rd_valid_reg | rd_first_reg | s1_valid_reg | s2_valid_reg;
    assign inside_res = inside_reg;

endmodule

`default_nettype wire

// File: design/pip_ctrl.sv
// Controller: command decode, vertex count, edge walk sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none

module pip_ctrl
    import pip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    output logic            out_valid,
    input  wire logic       out_stall,
    output pip_cmd_t        cmd,
    input  wire pip_stat_t  stat
);

    pip_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] last_idx;
    logic             in_acc;

    assign last_idx = count_reg - CNT_W'(1);
    assign in_acc   = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (command)
                        CMD_APPEND:
                        begin
                            // drop appends once the store is full
                            if (count_reg < CNT_W'(MAX_VERTICES))
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.addr   = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_TEST:
                        begin
                            cmd.start = 1'b1;
                            idx_next  = '0;
                            if (count_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                // fetch the closing vertex first
                                cmd.rd_en    = 1'b1;
                                cmd.rd_first = 1'b1;
                                cmd.addr     = last_idx[ADDR_W-1:0];
                                state_next   = ST_WALK;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.rd_en = 1'b1;
                cmd.addr  = idx_reg[ADDR_W-1:0];
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_res   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> idx_reg < count_reg)
        else $error("walk index past last vertex");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !stat.busy)
        else $error("edge pipeline busy while idle");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> !stat.busy)
        else $error("result loaded before pipeline drained");

endmodule

`default_nettype wire

// File: design/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon test.
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------
//   request | in_valid / in_stall       | command, x_coord, y_coord
//   result  | out_valid / out_stall     | inside_res
//
// Append and clear requests are handled in the idle state.
// A test takes vertex_count + 1 store reads, one per cycle from the single read port,
// then waits in the drain state for the edge pipeline to empty and loads the result in
// the finish state; an empty polygon goes straight to the finish state.
// Reset empties the polygon and clears the parity; the store itself is not cleared.
// A finished result waits in the output register while new requests are taken.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test
    import pip_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                command,
    input  wire logic signed [COORD_W-1:0] x_coord,
    input  wire logic signed [COORD_W-1:0] y_coord,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           inside_res
);

    pip_cmd_t  cmd;
    pip_stat_t stat;

    pip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    pip_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .stat      (stat),
        .inside_res(inside_res)
    );

endmodule

`default_nettype wire
